[design/encoder_position_trim_top_defines.svh]
// assertion macros shared by the trim block
`ifndef ENCODER_POSITION_TRIM_TOP_DEFINES_SVH
`define ENCODER_POSITION_TRIM_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define EPT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ept same-cycle check failed");

// next-cycle implication, checked out of reset
`define EPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ept next-cycle check failed");

`endif

[design/ept_pkg.sv]
package ept_pkg;

  // result status codes
  typedef enum logic [2:0] {
    ST_MOVE     = 3'd0,
    ST_REACHED  = 3'd1,
    ST_NOPROG   = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_LIMIT    = 3'd4,
    ST_IDLE     = 3'd5,
    ST_STARTED  = 3'd6
  } status_e;

  // input command codes
  typedef enum logic {
    CMD_START  = 1'b0,
    CMD_SAMPLE = 1'b1
  } command_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_TOLERANCE = 2'd0,
    REG_MAX_ATT   = 2'd1,
    REG_OVERSHOOT = 2'd2
  } reg_index_e;

  localparam logic [63:0] AbsErrReset  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] PosStepLimit = 64'h0000_0000_7FFF_FFFF;
  localparam logic [31:0] NegStepLimit = 32'h8000_0000;
  localparam logic [7:0]  MaxAttReset  = 8'd3;

  typedef struct packed {
    logic [15:0] tolerance;
    logic [7:0]  max_attempts;
    logic [15:0] reverse_overshoot;
  } cfg_t;

  typedef struct packed {
    logic [63:0] goal;
    logic [63:0] prev_abs_err;
    logic        overshoot_pending;
    logic [7:0]  attempt_count;
    logic        running;
  } trim_state_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] steps;
    logic [7:0]  attempt_index;
  } result_t;

endpackage

[design/ept_cfg.sv]
module ept_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [15:0]   cfg_wdata_i,
  output ept_pkg::cfg_t cfg_o
);
  import ept_pkg::*;

  cfg_t cfg_q, cfg_d;

  // register write decode, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (reg_index_e'(cfg_index_i))
        REG_TOLERANCE: cfg_d.tolerance         = cfg_wdata_i;
        REG_MAX_ATT:   cfg_d.max_attempts      = cfg_wdata_i[7:0];
        REG_OVERSHOOT: cfg_d.reverse_overshoot = cfg_wdata_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tolerance         <= '0;
      cfg_q.max_attempts      <= MaxAttReset;
      cfg_q.reverse_overshoot <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[design/ept_eval.sv]
module ept_eval (
  input  logic                 command_i,
  input  logic [63:0]          target_i,
  input  logic [63:0]          count_i,
  input  ept_pkg::cfg_t        cfg_i,
  input  ept_pkg::trim_state_t state_i,
  output ept_pkg::trim_state_t state_o,
  output ept_pkg::result_t     result_o
);
  import ept_pkg::*;

  logic        negative;
  logic [63:0] diff_gc;
  logic [63:0] diff_cg;
  logic [63:0] mag;
  logic        within_tol;
  logic        crossing;
  logic        no_progress;
  logic [31:0] neg_limit;
  logic        ovf_neg;
  logic        ovf_pos;
  logic [31:0] steps_neg;
  logic        final_check;

  // exact error magnitude, both directions computed side by side
  assign negative  = $signed(state_i.goal) < $signed(count_i);
  assign diff_gc   = state_i.goal - count_i;
  assign diff_cg   = count_i - state_i.goal;
  assign mag       = negative ? diff_cg : diff_gc;

  // decision terms
  assign within_tol  = mag <= {48'd0, cfg_i.tolerance};
  assign crossing    = state_i.overshoot_pending && !negative;
  assign no_progress = !crossing && (mag >= state_i.prev_abs_err);
  assign neg_limit   = NegStepLimit - {16'd0, cfg_i.reverse_overshoot};
  assign ovf_neg     = mag > {32'd0, neg_limit};
  assign ovf_pos     = mag > PosStepLimit;
  assign steps_neg   = 32'd0 - (mag[31:0] + {16'd0, cfg_i.reverse_overshoot});
  assign final_check = state_i.attempt_count >= cfg_i.max_attempts;

  // next state and result
  always_comb begin
    state_o                = state_i;
    result_o.status        = ST_MOVE;
    result_o.steps         = '0;
    result_o.attempt_index = state_i.attempt_count;
    if (command_e'(command_i) == CMD_START) begin
      state_o.goal              = target_i;
      state_o.prev_abs_err      = AbsErrReset;
      state_o.overshoot_pending = 1'b0;
      state_o.attempt_count     = '0;
      state_o.running           = 1'b1;
      result_o.status           = ST_STARTED;
      result_o.attempt_index    = '0;
    end else if (!state_i.running) begin
      result_o.status        = ST_IDLE;
      result_o.attempt_index = '0;
    end else if (final_check) begin
      state_o.running = 1'b0;
      result_o.status = within_tol ? ST_REACHED : ST_LIMIT;
    end else if (within_tol) begin
      state_o.running = 1'b0;
      result_o.status = ST_REACHED;
    end else if (no_progress) begin
      state_o.running = 1'b0;
      result_o.status = ST_NOPROG;
    end else if (negative ? ovf_neg : ovf_pos) begin
      state_o.running = 1'b0;
      result_o.status = ST_OVERFLOW;
    end else begin
      // issue a correction
      state_o.prev_abs_err      = mag;
      state_o.attempt_count     = state_i.attempt_count + 8'd1;
      state_o.overshoot_pending = negative && (cfg_i.reverse_overshoot != 16'd0);
      result_o.steps            = negative ? steps_neg : mag[31:0];
    end
  end

endmodule

[design/encoder_position_trim_top.sv]
// Encoder position trim controller. Every transaction in gives exactly one
// result transaction out: a start loads the target and answers "started",
// each settled encoder sample answers move (with a signed step count),
// reached, no progress, overflow or limit missed, and a sample while idle
// answers "idle ignored". One item is taken per cycle unless stalled; each
// passes the input register, then the result register, with the full error
// compare between the two. A held output stall backs up into in_stall_o in
// the same cycle once both registers are full. The user must write
// configuration through the plain write port while no work is in flight;
// unchecked by the block. Reset: tolerance 0, max attempts 3, overshoot 0.
module encoder_position_trim_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [63:0] target_position_i,
  input  logic [63:0] encoder_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] correction_steps_o,
  output logic [7:0]  attempt_index_o
);
  import ept_pkg::*;

  `include "encoder_position_trim_top_defines.svh"

  cfg_t        cfg;
  trim_state_t state_q, state_d;
  result_t     result_d, result_q;

  logic        in_valid_q;
  logic        cmd_q;
  logic [63:0] target_q;
  logic [63:0] count_q;
  logic        out_valid_q;
  logic        out_free;
  logic        fire;
  logic        in_take;

  ept_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ept_eval u_eval (
    .command_i (cmd_q),
    .target_i  (target_q),
    .count_i   (count_q),
    .cfg_i     (cfg),
    .state_i   (state_q),
    .state_o   (state_d),
    .result_o  (result_d)
  );

  // handshake between the two register stages
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q    <= command_i;
      target_q <= target_position_i;
      count_q  <= encoder_count_i;
    end
  end

  // trim state, updated as each item completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.goal              <= '0;
      state_q.prev_abs_err      <= AbsErrReset;
      state_q.overshoot_pending <= 1'b0;
      state_q.attempt_count     <= '0;
      state_q.running           <= 1'b0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = result_q.status;
  assign correction_steps_o = result_q.steps;
  assign attempt_index_o    = result_q.attempt_index;

  // only a move carries a step count
  `EPT_ASSERT_SAME(a_steps_zero, clk_i, rst_ni,
    out_valid_q && (result_q.status != ST_MOVE), result_q.steps == 32'd0)
  // an accepted item always lands in the input register
  `EPT_ASSERT_NEXT(a_in_lands, clk_i, rst_ni, in_take, in_valid_q)
  // each issued move advances the attempt count by one
  `EPT_ASSERT_NEXT(a_move_counts, clk_i, rst_ni, fire && (result_d.status == ST_MOVE),
    state_q.attempt_count == $past(state_q.attempt_count) + 8'd1)

endmodule

[bench/ept_trim_sb_pkg.sv]
package ept_trim_sb_pkg;
  import ept_pkg::*;

  // tracks trim state per accepted transaction and holds expected results in order
  class trim_scoreboard;
    cfg_t        cfg;
    trim_state_t st;
    result_t     expected_q[$];
    int unsigned errors;

    function new();
      cfg.tolerance         = '0;
      cfg.max_attempts      = MaxAttReset;
      cfg.reverse_overshoot = '0;
      st.goal               = '0;
      st.prev_abs_err       = AbsErrReset;
      st.overshoot_pending  = 1'b0;
      st.attempt_count      = '0;
      st.running            = 1'b0;
      errors                = 0;
    endfunction

    function void write_reg(input reg_index_e idx, input logic [15:0] data);
      case (idx)
        REG_TOLERANCE: cfg.tolerance = data;
        REG_MAX_ATT:   cfg.max_attempts = data[7:0];
        REG_OVERSHOOT: cfg.reverse_overshoot = data;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void flag(input string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    // work out the result of one accepted transaction and advance the trim state
    function void note_input(input command_e cmd, input logic [63:0] tgt,
                             input logic [63:0] cnt);
      result_t     r;
      logic [63:0] mag;
      logic [63:0] ovs;
      logic        neg;
      r.status        = ST_MOVE;
      r.steps         = '0;
      r.attempt_index = st.attempt_count;
      ovs             = 64'(cfg.reverse_overshoot);
      if (cmd == CMD_START) begin
        st.goal              = tgt;
        st.prev_abs_err      = AbsErrReset;
        st.overshoot_pending = 1'b0;
        st.attempt_count     = '0;
        st.running           = 1'b1;
        r.status             = ST_STARTED;
        r.attempt_index      = '0;
      end else if (!st.running) begin
        r.status        = ST_IDLE;
        r.attempt_index = '0;
      end else begin
        // exact error magnitude, direction from the signed compare
        neg        = $signed(st.goal) < $signed(cnt);
        mag        = neg ? cnt - st.goal : st.goal - cnt;
        st.running = 1'b0;
        if (st.attempt_count >= cfg.max_attempts) begin
          r.status = (mag <= 64'(cfg.tolerance)) ? ST_REACHED : ST_LIMIT;
        end else if (mag <= 64'(cfg.tolerance)) begin
          r.status = ST_REACHED;
        end else if (!(st.overshoot_pending && !neg) && mag >= st.prev_abs_err) begin
          r.status = ST_NOPROG;
        end else if (neg ? (mag > {32'h0, NegStepLimit} - ovs) : (mag > PosStepLimit)) begin
          r.status = ST_OVERFLOW;
        end else begin
          // reverse moves carry the overshoot margin
          r.steps              = neg ? 32'(64'd0 - (mag + ovs)) : mag[31:0];
          st.overshoot_pending = neg && (ovs != 0);
          st.prev_abs_err      = mag;
          st.attempt_count     = st.attempt_count + 8'd1;
          st.running           = 1'b1;
        end
      end
      expected_q.push_back(r);
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(input logic [2:0] status, input logic [31:0] steps,
                               input logic [7:0] idx);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        flag($sformatf("result with nothing expected: status %0d steps %0d index %0d",
                       status, $signed(steps), idx));
        return;
      end
      exp_r = expected_q.pop_front();
      if (status !== exp_r.status || steps !== exp_r.steps || idx !== exp_r.attempt_index)
        flag($sformatf("status exp %0d got %0d, steps exp %0d got %0d, index exp %0d got %0d",
                       exp_r.status, status, $signed(exp_r.steps), $signed(steps),
                       exp_r.attempt_index, idx));
    endfunction
  endclass

endpackage

[bench/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ept_pkg::*;
  import ept_trim_sb_pkg::*;

  localparam int ClkPeriod   = 10;
  localparam int DrainSettle = 4;
  localparam int QuietLimit  = 5000;
  localparam int PhaseItems  = 230;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        command_i;
  logic [63:0] target_position_i;
  logic [63:0] encoder_count_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  status_o;
  logic [31:0] correction_steps_o;
  logic [7:0]  attempt_index_o;

  trim_scoreboard sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned quiet_cycles  = 0;
  logic [15:0] cur_tol = '0;
  logic [7:0]  cur_max = MaxAttReset;
  logic [15:0] cur_ovs = '0;

  encoder_position_trim_top uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .target_position_i  (target_position_i),
    .encoder_count_i    (encoder_count_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .correction_steps_o (correction_steps_o),
    .attempt_index_o    (attempt_index_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // observe both channels at the edge where a transaction completes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.note_input(command_e'(command_i), target_position_i, encoder_count_i);
      if (out_valid_o && !out_stall_i)
        sb.check_result(status_o, correction_steps_o, attempt_index_o);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // fresh error: near tolerance, moderate, around the step limit, wide or anything
  function automatic logic signed [63:0] pick_error();
    logic [63:0] mag;
    case ($urandom_range(9))
      0, 1, 2, 3: mag = 64'($urandom_range(0, 3 * cur_tol + 20));
      4, 5, 6: mag = 64'($urandom_range(0, 1 << 20));
      7: begin
        mag = 64'h7FFF_FFFE + $urandom_range(0, 3);
        if ($urandom_range(1)) mag = mag - 64'(cur_ovs);
      end
      8: mag = {24'h0, 8'($urandom), $urandom};
      default: mag = rand64();
    endcase
    return $urandom_range(1) ? 64'd0 - mag : mag;
  endfunction

  // error after a move: mostly shrinking, sometimes past the target or lost
  function automatic logic signed [63:0] follow_error(input logic signed [63:0] err);
    logic [63:0] mag;
    logic [63:0] nxt;
    mag = err[63] ? 64'd0 - err : err;
    nxt = (mag >> $urandom_range(1, 3)) + $urandom_range(0, 3);
    case ($urandom_range(9))
      0: return pick_error();
      1, 2: begin
        // reverse move overshot, error turns positive and may grow
        if (err[63]) return (mag >> $urandom_range(0, 2)) + $urandom_range(0, cur_ovs);
        return 64'd0 - nxt;
      end
      3: return err[63] ? nxt : 64'd0 - nxt;
      default: return err[63] ? 64'd0 - nxt : nxt;
    endcase
  endfunction

  // one input transaction, with random sender gaps before it
  task automatic send_txn(input command_e cmd, input logic [63:0] tgt, input logic [63:0] cnt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    command_i         <= cmd;
    target_position_i <= tgt;
    encoder_count_i   <= cnt;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
  endtask

  task automatic start_trim(input logic [63:0] tgt);
    send_txn(CMD_START, tgt, rand64());
  endtask

  task automatic sample_trim(input logic [63:0] cnt);
    send_txn(CMD_SAMPLE, rand64(), cnt);
  endtask

  // hold the sender until every outstanding result has come back
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (DrainSettle) @(posedge clk_i);
  endtask

  // write all three registers, upper bits of the attempt limit are don't care
  task automatic load_trim_config(input logic [15:0] tol, input logic [7:0] max_att,
                                  input logic [15:0] ovs);
    logic [15:0] max_word;
    max_word = {8'($urandom), max_att};
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_TOLERANCE;
    cfg_wdata_i <= tol;
    sb.write_reg(REG_TOLERANCE, tol);
    @(posedge clk_i);
    cfg_index_i <= REG_MAX_ATT;
    cfg_wdata_i <= max_word;
    sb.write_reg(REG_MAX_ATT, max_word);
    @(posedge clk_i);
    cfg_index_i <= REG_OVERSHOOT;
    cfg_wdata_i <= ovs;
    sb.write_reg(REG_OVERSHOOT, ovs);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_tol  = tol;
    cur_max  = max_att;
    cur_ovs  = ovs;
  endtask

  // start plus a run of settled samples converging on the target
  task automatic run_trim_sequence(inout int unsigned count);
    logic [63:0]        goal_pos;
    logic signed [63:0] err;
    int unsigned        n_samples;
    goal_pos = rand64();
    if ($urandom_range(3) != 0) goal_pos = {{24{goal_pos[39]}}, goal_pos[39:0]};
    n_samples = $urandom_range(1, (cur_max < 8) ? cur_max + 2 : 10);
    start_trim(goal_pos);
    err = pick_error();
    repeat (n_samples) begin
      sample_trim(goal_pos - err);
      err = follow_error(err);
    end
    count += n_samples + 1;
  endtask

  initial begin
    int unsigned items;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_index_i       = REG_TOLERANCE;
    cfg_wdata_i       = '0;
    in_valid_i        = 1'b0;
    command_i         = CMD_SAMPLE;
    target_position_i = '0;
    encoder_count_i   = '0;
    out_stall_i       = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset register values
    sample_trim(64'h8000_0000_0000_0000);      // sample while idle
    start_trim(64'h7FFF_FFFF_FFFF_FFFF);
    sample_trim(64'h8000_0000_0000_0000);      // widest error, no progress
    start_trim(64'd0);
    sample_trim(64'hFFFF_FFFF_8000_0000);      // forward step just out of range
    start_trim(64'd0);
    sample_trim(64'h0000_0000_8000_0001);      // reverse step just out of range
    start_trim(64'd0);
    sample_trim(64'h0000_0000_8000_0000);      // largest reverse step
    sample_trim(64'hFFFF_FFFF_8000_0001);      // largest forward step
    sample_trim(64'd1000);
    sample_trim(64'd1000);                     // final check after the limit
    start_trim(64'd500);
    sample_trim(64'd400);
    start_trim(-64'sd5);                       // restart while running
    sample_trim(-64'sd5);
    wait_results_drained();

    // directed, overshoot and crossing
    load_trim_config(16'd5, 8'd2, 16'd10);
    start_trim(64'd0);
    sample_trim(64'd100);
    sample_trim(-64'sd200);                    // crossed after overshoot, larger error allowed
    sample_trim(64'd3);
    start_trim(64'd0);
    sample_trim(64'd50);
    sample_trim(64'd60);
    wait_results_drained();

    // directed, register extremes with no moves allowed
    load_trim_config(16'hFFFF, 8'd0, 16'hFFFF);
    start_trim(64'd0);
    sample_trim(64'd70000);
    sample_trim(64'd7);
    wait_results_drained();

    // random phases over register settings and idling patterns
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 78; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 78; end
        default: begin send_idle_pct = 33; stall_pct = 33; end
      endcase
      case (p)
        0: load_trim_config(16'd0, 8'd3, 16'd0);
        1: load_trim_config(16'hFFFF, 8'd255, 16'hFFFF);
        2: load_trim_config(16'd0, 8'd0, 16'd1);
        3: load_trim_config(16'($urandom_range(0, 200)), 8'($urandom_range(1, 8)),
                            16'($urandom_range(0, 300)));
        4: load_trim_config(16'd1, 8'd255, 16'd0);
        6: load_trim_config(16'($urandom), 8'($urandom), 16'($urandom));
        default: load_trim_config(16'($urandom_range(0, 50)), 8'($urandom_range(1, 6)),
                                  16'($urandom_range(0, 40)));
      endcase
      items = 0;
      while (items < PhaseItems) begin
        if ($urandom_range(6) == 0) begin
          send_txn(command_e'($urandom_range(1)), rand64(), rand64());
        end else begin
          run_trim_sequence(items);
        end
      end
      wait_results_drained();
    end

    repeat (DrainSettle) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/ept_pkg.sv
design/ept_cfg.sv
design/ept_eval.sv
design/encoder_position_trim_top.sv
bench/ept_trim_sb_pkg.sv
bench/tb_top.sv
